@@ src/power_receiver_fault_monitor_assert.svh @@
// Assertion macros used by the RTL core (prfm_core).
`ifndef POWER_RECEIVER_FAULT_MONITOR_ASSERT_SVH
`define POWER_RECEIVER_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRFM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRFM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/prfm_pkg.sv @@
`default_nettype none

package prfm_pkg;

    // Averaging block length; must be a power of two.
    localparam int unsigned SAMPLES_PER_AVERAGE = 16;
    localparam int unsigned PERSIST_WIDTH       = 8;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned TEMP_W    = 13;
    localparam int unsigned AVG_SHIFT = $clog2(SAMPLES_PER_AVERAGE);
    localparam int unsigned SUM_W     = SAMPLE_W + AVG_SHIFT;
    localparam int unsigned CNT_W     = $clog2(SAMPLES_PER_AVERAGE + 1);

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned LANE_TEMP   = 0;
    localparam int unsigned LANE_VOLT   = 1;
    localparam int unsigned LANE_CURR   = 2;
    localparam int unsigned LANE_CHARGE = 3;

    localparam logic [PERSIST_WIDTH-1:0] PERSIST_MAX = '1;
    localparam int unsigned PERSIST_LIMIT [NUM_LANES] = '{99, 5, 99, 199};

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_TUSER_W = 1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVERTEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVERVOLT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVERCURRENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL_VOLT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_CURRENT = 3'd4;

    localparam logic [TEMP_W-1:0]   RST_OVERTEMP    = 13'd1280;
    localparam logic [SAMPLE_W-1:0] RST_OVERVOLT    = 16'd20000;
    localparam logic [SAMPLE_W-1:0] RST_OVERCURRENT = 16'd2000;
    localparam logic [SAMPLE_W-1:0] RST_FULL_VOLT   = 16'd4200;
    localparam logic [SAMPLE_W-1:0] RST_LOW_CURRENT = 16'd50;

    typedef enum logic [1:0] {
        REQ_ADC     = 2'd0,
        REQ_TEMP    = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_CONNECT = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t           req_type;
        logic [SAMPLE_W-1:0] voltage_sample;
        logic [SAMPLE_W-1:0] current_sample;
        logic [TEMP_W-1:0]   temp_reading;
        logic                temp_read_ok;
    } in_item_t;

    typedef struct packed {
        logic [NUM_LANES-1:0] alert_flags;
        logic [SAMPLE_W-1:0]  avg_voltage;
        logic [SAMPLE_W-1:0]  avg_current;
        logic                 avg_updated;
    } result_t;

    typedef struct packed {
        logic [TEMP_W-1:0]   overtemp_limit;
        logic [SAMPLE_W-1:0] overvolt_limit;
        logic [SAMPLE_W-1:0] overcurrent_limit;
        logic [SAMPLE_W-1:0] full_voltage_limit;
        logic [SAMPLE_W-1:0] low_current_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/power_receiver_fault_monitor.sv @@
// Fault monitor for a wireless power receiver. Each input item is an ADC sample, a
// temperature reading, an alert tick or a connect event (s_tuser), and each yields
// exactly one result item carrying the sticky alert flags and the latest block
// averages. Items are taken at one per clock while the output is not stalled: an
// input register feeds a single pass of update logic into the result register, so a
// result shows on m_tvalid right after the edge at which its item leaves the input
// register, and can be taken at the next edge. s_tready drops only while both
// registers hold an item and m_tready is low. Averages are block sums of
// SAMPLES_PER_AVERAGE samples, truncated. Limits are to be written over the cfg
// port only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module power_receiver_fault_monitor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // voltage_sample[15:0], current_sample[31:16], temp_reading[44:32],
    // temp_read_ok[45], zero pad [47:46]
    input  wire logic [prfm_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [prfm_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // alert_flags[3:0], avg_voltage[19:4], avg_current[35:20], zero pad [39:36]
    output logic [prfm_pkg::M_TDATA_W-1:0]       m_tdata,
    // avg_updated[0]
    output logic [prfm_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [prfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [prfm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    prfm_pkg::cfg_t      cfg;
    prfm_pkg::in_item_t  item;
    prfm_pkg::result_t   result;
    logic                advance;
    logic                fire;

    prfm_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    prfm_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .fire     (fire),
        .item     (item)
    );

    prfm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    prfm_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .fire     (fire),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ src/prfm_cfg_regs.sv @@
`default_nettype none

module prfm_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             wr_en,
    input  wire logic [prfm_pkg::CFG_IDX_W-1:0]   index,
    input  wire logic [prfm_pkg::CFG_DATA_W-1:0]  wdata,
    output prfm_pkg::cfg_t                        cfg
);

    prfm_pkg::cfg_t cfg_reg;
    prfm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                prfm_pkg::CFG_IDX_OVERTEMP:
                    cfg_next.overtemp_limit = wdata[prfm_pkg::TEMP_W-1:0];
                prfm_pkg::CFG_IDX_OVERVOLT:
                    cfg_next.overvolt_limit = wdata[prfm_pkg::SAMPLE_W-1:0];
                prfm_pkg::CFG_IDX_OVERCURRENT:
                    cfg_next.overcurrent_limit = wdata[prfm_pkg::SAMPLE_W-1:0];
                prfm_pkg::CFG_IDX_FULL_VOLT:
                    cfg_next.full_voltage_limit = wdata[prfm_pkg::SAMPLE_W-1:0];
                prfm_pkg::CFG_IDX_LOW_CURRENT:
                    cfg_next.low_current_limit = wdata[prfm_pkg::SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overtemp_limit     <= prfm_pkg::RST_OVERTEMP;
            cfg_reg.overvolt_limit     <= prfm_pkg::RST_OVERVOLT;
            cfg_reg.overcurrent_limit  <= prfm_pkg::RST_OVERCURRENT;
            cfg_reg.full_voltage_limit <= prfm_pkg::RST_FULL_VOLT;
            cfg_reg.low_current_limit  <= prfm_pkg::RST_LOW_CURRENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/prfm_in_stage.sv @@
`default_nettype none

module prfm_in_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [prfm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [prfm_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            advance,
    output logic                                 fire,
    output prfm_pkg::in_item_t                   item
);

    logic               valid_reg;
    logic               valid_next;
    prfm_pkg::in_item_t item_reg;
    prfm_pkg::in_item_t item_in;
    logic               accept;

    always_comb begin
        item_in.req_type       = prfm_pkg::req_type_t'(s_tuser);
        item_in.voltage_sample = s_tdata[15:0];
        item_in.current_sample = s_tdata[31:16];
        item_in.temp_reading   = s_tdata[44:32];
        item_in.temp_read_ok   = s_tdata[45];
    end

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign fire     = valid_reg && advance;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

@@ src/prfm_core.sv @@
`default_nettype none
`include "power_receiver_fault_monitor_assert.svh"

module prfm_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fire,
    input  wire prfm_pkg::in_item_t  item,
    input  wire prfm_pkg::cfg_t      cfg,
    output prfm_pkg::result_t        result
);

    localparam int unsigned SUM_W = prfm_pkg::SUM_W;
    localparam int unsigned CNT_W = prfm_pkg::CNT_W;
    localparam int unsigned SMP_W = prfm_pkg::SAMPLE_W;
    localparam int unsigned PW    = prfm_pkg::PERSIST_WIDTH;
    localparam int unsigned NL    = prfm_pkg::NUM_LANES;

    logic [SUM_W-1:0]           vsum_reg, vsum_next;
    logic [SUM_W-1:0]           isum_reg, isum_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SMP_W-1:0]           vavg_reg, vavg_next;
    logic [SMP_W-1:0]           iavg_reg, iavg_next;
    logic [prfm_pkg::TEMP_W-1:0] temp_slot_reg [2];
    logic [prfm_pkg::TEMP_W-1:0] temp_slot_next [2];
    logic                       slot_sel_reg, slot_sel_next;
    logic [PW-1:0]              persist_cnt_reg [NL];
    logic [PW-1:0]              persist_cnt_next [NL];
    logic [PW-1:0]              cnt_bump [NL];
    logic [NL-1:0]              alerts_reg, alerts_next;
    logic [NL-1:0]              hit;
    logic [SUM_W-1:0]           vsum_add, isum_add;
    logic [CNT_W-1:0]           count_inc;
    logic                       avg_done;
    logic                       updated;

    assign count_inc = count_reg + CNT_W'(1);
    assign avg_done  = (count_inc >= CNT_W'(prfm_pkg::SAMPLES_PER_AVERAGE));
    assign vsum_add  = vsum_reg + SUM_W'(item.voltage_sample);
    assign isum_add  = isum_reg + SUM_W'(item.current_sample);

    always_comb begin
        hit[prfm_pkg::LANE_TEMP] =
            ($signed(temp_slot_reg[0]) > $signed(cfg.overtemp_limit)) ||
            ($signed(temp_slot_reg[1]) > $signed(cfg.overtemp_limit));
        hit[prfm_pkg::LANE_VOLT]   = vavg_reg > cfg.overvolt_limit;
        hit[prfm_pkg::LANE_CURR]   = iavg_reg > cfg.overcurrent_limit;
        hit[prfm_pkg::LANE_CHARGE] = (vavg_reg > cfg.full_voltage_limit) &&
                                     (iavg_reg < cfg.low_current_limit);
        for (int i = 0; i < NL; i++) begin
            cnt_bump[i] = (persist_cnt_reg[i] == prfm_pkg::PERSIST_MAX) ?
                          persist_cnt_reg[i] : persist_cnt_reg[i] + PW'(1);
        end
    end

    always_comb begin
        vsum_next      = vsum_reg;
        isum_next      = isum_reg;
        count_next     = count_reg;
        vavg_next      = vavg_reg;
        iavg_next      = iavg_reg;
        temp_slot_next = temp_slot_reg;
        slot_sel_next  = slot_sel_reg;
        persist_cnt_next = persist_cnt_reg;
        alerts_next    = alerts_reg;
        updated        = 1'b0;
        case (item.req_type)
            prfm_pkg::REQ_ADC: begin
                if (avg_done) begin
                    vavg_next  = vsum_add[SUM_W-1 -: SMP_W];
                    iavg_next  = isum_add[SUM_W-1 -: SMP_W];
                    vsum_next  = '0;
                    isum_next  = '0;
                    count_next = '0;
                    updated    = 1'b1;
                end else begin
                    vsum_next  = vsum_add;
                    isum_next  = isum_add;
                    count_next = count_inc;
                end
            end
            prfm_pkg::REQ_TEMP: begin
                if (item.temp_read_ok) begin
                    temp_slot_next[slot_sel_reg] = item.temp_reading;
                end
                slot_sel_next = !slot_sel_reg;
            end
            prfm_pkg::REQ_TICK: begin
                for (int i = 0; i < NL; i++) begin
                    if (hit[i]) begin
                        persist_cnt_next[i] = cnt_bump[i];
                        if (cnt_bump[i] > PW'(prfm_pkg::PERSIST_LIMIT[i])) begin
                            alerts_next[i] = 1'b1;
                        end
                    end
                end
            end
            prfm_pkg::REQ_CONNECT: begin
                for (int i = 0; i < NL; i++) begin
                    persist_cnt_next[i] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsum_reg      <= '0;
            isum_reg      <= '0;
            count_reg     <= '0;
            vavg_reg      <= '0;
            iavg_reg      <= '0;
            temp_slot_reg <= '{default: '0};
            slot_sel_reg  <= 1'b0;
            persist_cnt_reg <= '{default: '0};
            alerts_reg    <= '0;
        end else if (fire) begin
            vsum_reg      <= vsum_next;
            isum_reg      <= isum_next;
            count_reg     <= count_next;
            vavg_reg      <= vavg_next;
            iavg_reg      <= iavg_next;
            temp_slot_reg <= temp_slot_next;
            slot_sel_reg  <= slot_sel_next;
            persist_cnt_reg <= persist_cnt_next;
            alerts_reg    <= alerts_next;
        end
    end

    always_comb begin
        result.alert_flags = alerts_next;
        result.avg_voltage = vavg_next;
        result.avg_current = iavg_next;
        result.avg_updated = updated;
    end

    `PRFM_ASSERT_NEXT(a_alerts_sticky, aclk, aresetn, 1'b1,
        (alerts_reg & $past(alerts_reg)) == $past(alerts_reg),
        "sticky alert bit cleared")
    `PRFM_ASSERT_NEXT(a_alerts_only_on_tick, aclk, aresetn,
        !(fire && item.req_type == prfm_pkg::REQ_TICK),
        alerts_reg == $past(alerts_reg), "alert changed outside a tick")
    `PRFM_ASSERT_NEXT(a_avg_restarts_block, aclk, aresetn,
        fire && item.req_type == prfm_pkg::REQ_ADC && avg_done,
        count_reg == '0 && vsum_reg == '0 && isum_reg == '0,
        "averaging block not restarted")
    `PRFM_ASSERT_NEXT(a_connect_clears, aclk, aresetn,
        fire && item.req_type == prfm_pkg::REQ_CONNECT,
        persist_cnt_reg[0] == '0 && persist_cnt_reg[1] == '0 &&
        persist_cnt_reg[2] == '0 && persist_cnt_reg[3] == '0,
        "connect left a counter running")

endmodule

`default_nettype wire

@@ src/prfm_out_stage.sv @@
`default_nettype none

module prfm_out_stage (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire prfm_pkg::result_t               result,
    input  wire logic                            fire,
    output logic                                 advance,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [prfm_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [prfm_pkg::M_TUSER_W-1:0]       m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    prfm_pkg::result_t result_reg;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, result_reg.avg_current, result_reg.avg_voltage,
                       result_reg.alert_flags};
    assign m_tuser  = result_reg.avg_updated;

endmodule

`default_nettype wire

@@ sim/fault_monitor_check.sv @@
`timescale 1ns / 1ps

module fault_monitor_check
    import prfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic [M_TUSER_W-1:0]  m_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned                mismatch_count,
    output int unsigned                outstanding
);

    logic signed [TEMP_W-1:0] lim_temp;
    logic [SAMPLE_W-1:0]      lim_volt;
    logic [SAMPLE_W-1:0]      lim_curr;
    logic [SAMPLE_W-1:0]      lim_full;
    logic [SAMPLE_W-1:0]      lim_low;

    logic [SUM_W-1:0]         volt_acc;
    logic [SUM_W-1:0]         curr_acc;
    int unsigned              adc_seen;
    logic [SAMPLE_W-1:0]      volt_avg;
    logic [SAMPLE_W-1:0]      curr_avg;
    logic signed [TEMP_W-1:0] temp_slot [2];
    logic                     slot_sel;
    logic [PERSIST_WIDTH-1:0] persist_cnt [NUM_LANES];
    logic [NUM_LANES-1:0]     alerts;

    result_t                  pending_results [$];
    result_t                  got;
    result_t                  want;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    task automatic bump_lane(input int unsigned lane, input logic hit);
        if (hit) begin
            if (persist_cnt[lane] != PERSIST_MAX) begin
                persist_cnt[lane]++;
            end
            if (persist_cnt[lane] > PERSIST_LIMIT[lane]) begin
                alerts[lane] = 1'b1;
            end
        end
    endtask

    task automatic apply_item(
        input  req_type_t                kind,
        input  logic [SAMPLE_W-1:0]      volt,
        input  logic [SAMPLE_W-1:0]      curr,
        input  logic signed [TEMP_W-1:0] temp,
        input  logic                     temp_ok,
        output result_t                  res
    );
        logic updated;
        updated = 1'b0;
        case (kind)
            REQ_ADC: begin
                volt_acc += volt;
                curr_acc += curr;
                adc_seen++;
                if (adc_seen >= SAMPLES_PER_AVERAGE) begin
                    volt_avg = SAMPLE_W'(volt_acc / SAMPLES_PER_AVERAGE);
                    curr_avg = SAMPLE_W'(curr_acc / SAMPLES_PER_AVERAGE);
                    volt_acc = '0;
                    curr_acc = '0;
                    adc_seen = 0;
                    updated  = 1'b1;
                end
            end
            REQ_TEMP: begin
                // failed read still advances the slot pointer
                if (temp_ok) begin
                    temp_slot[slot_sel] = temp;
                end
                slot_sel = ~slot_sel;
            end
            REQ_TICK: begin
                bump_lane(LANE_TEMP, temp_slot[0] > lim_temp || temp_slot[1] > lim_temp);
                bump_lane(LANE_VOLT, volt_avg > lim_volt);
                bump_lane(LANE_CURR, curr_avg > lim_curr);
                bump_lane(LANE_CHARGE, volt_avg > lim_full && curr_avg < lim_low);
            end
            REQ_CONNECT: begin
                foreach (persist_cnt[i]) begin
                    persist_cnt[i] = '0;
                end
            end
            default: begin
            end
        endcase
        res.alert_flags = alerts;
        res.avg_voltage = volt_avg;
        res.avg_current = curr_avg;
        res.avg_updated = updated;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_temp = RST_OVERTEMP;
            lim_volt = RST_OVERVOLT;
            lim_curr = RST_OVERCURRENT;
            lim_full = RST_FULL_VOLT;
            lim_low  = RST_LOW_CURRENT;
            volt_acc = '0;
            curr_acc = '0;
            adc_seen = 0;
            volt_avg = '0;
            curr_avg = '0;
            temp_slot[0] = '0;
            temp_slot[1] = '0;
            slot_sel = 1'b0;
            foreach (persist_cnt[i]) begin
                persist_cnt[i] = '0;
            end
            alerts = '0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.alert_flags = m_tdata[3:0];
                got.avg_voltage = m_tdata[19:4];
                got.avg_current = m_tdata[35:20];
                got.avg_updated = m_tuser[0];
                if (pending_results.size() == 0) begin
                    $error("result item with nothing expected: m_tdata=%h m_tuser=%h",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.alert_flags !== want.alert_flags) begin
                        $error("alert_flags: expected %h, got %h",
                               want.alert_flags, got.alert_flags);
                        mismatch_count++;
                    end
                    if (got.avg_voltage !== want.avg_voltage) begin
                        $error("avg_voltage: expected %0d, got %0d",
                               want.avg_voltage, got.avg_voltage);
                        mismatch_count++;
                    end
                    if (got.avg_current !== want.avg_current) begin
                        $error("avg_current: expected %0d, got %0d",
                               want.avg_current, got.avg_current);
                        mismatch_count++;
                    end
                    if (got.avg_updated !== want.avg_updated) begin
                        $error("avg_updated: expected %b, got %b",
                               want.avg_updated, got.avg_updated);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IDX_OVERTEMP:    lim_temp = cfg_wdata[TEMP_W-1:0];
                    CFG_IDX_OVERVOLT:    lim_volt = cfg_wdata;
                    CFG_IDX_OVERCURRENT: lim_curr = cfg_wdata;
                    CFG_IDX_FULL_VOLT:   lim_full = cfg_wdata;
                    CFG_IDX_LOW_CURRENT: lim_low  = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_item(req_type_t'(s_tuser[1:0]), s_tdata[15:0], s_tdata[31:16],
                           s_tdata[44:32], s_tdata[45], want);
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

@@ sim/power_receiver_fault_monitor_tb.sv @@
`timescale 1ns / 1ps

module power_receiver_fault_monitor_tb;
    import prfm_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 64;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire logic             s_tready;
    wire logic [M_TDATA_W-1:0] m_tdata;
    wire logic [M_TUSER_W-1:0] m_tuser;
    wire logic             m_tvalid;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned quiet_cycles = 0;

    bit          calm    = 1'b0;
    bit          rx_hold = 1'b0;
    cfg_t        limits;
    int unsigned tick_pct;
    int unsigned connect_pct;
    int unsigned temp_pct;
    int unsigned adc_in_block = 0;
    logic [SAMPLE_W-1:0] volt_center;
    logic [SAMPLE_W-1:0] curr_center;

    always #10 aclk = ~aclk;

    power_receiver_fault_monitor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fault_monitor_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // result side: random backpressure, or one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(
        input req_type_t           kind,
        input logic [SAMPLE_W-1:0] volt,
        input logic [SAMPLE_W-1:0] curr,
        input logic [TEMP_W-1:0]   temp,
        input logic                temp_ok
    );
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, temp_ok, temp, curr, volt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_limits(input cfg_t lim);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_OVERTEMP;
        cfg_wdata <= CFG_DATA_W'(lim.overtemp_limit);
        @(negedge aclk);
        cfg_index <= CFG_IDX_OVERVOLT;
        cfg_wdata <= lim.overvolt_limit;
        @(negedge aclk);
        cfg_index <= CFG_IDX_OVERCURRENT;
        cfg_wdata <= lim.overcurrent_limit;
        @(negedge aclk);
        cfg_index <= CFG_IDX_FULL_VOLT;
        cfg_wdata <= lim.full_voltage_limit;
        @(negedge aclk);
        cfg_index <= CFG_IDX_LOW_CURRENT;
        cfg_wdata <= lim.low_current_limit;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        limits = lim;
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_near(input logic [SAMPLE_W-1:0] center);
        int unsigned roll;
        int          val;
        roll = $urandom_range(99);
        if (roll < 4) begin
            return $urandom_range(1) ? '1 : '0;
        end
        if (roll < 12) begin
            return SAMPLE_W'($urandom);
        end
        val = int'(center) + int'($urandom_range(400)) - 200;
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        return SAMPLE_W'(val);
    endfunction

    function automatic logic [TEMP_W-1:0] temp_near_limit();
        int unsigned roll;
        int          val;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return $urandom_range(1) ? 13'h0FFF : 13'h1000;
        end
        if (roll < 30) begin
            return TEMP_W'($urandom);
        end
        val = int'($signed(limits.overtemp_limit)) + int'($urandom_range(96)) - 48;
        if (val < -4096) val = -4096;
        if (val > 4095) val = 4095;
        return TEMP_W'(val);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_center(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        case ($urandom_range(2))
            0:       return a;
            1:       return b;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int unsigned         roll;
        logic [SAMPLE_W-1:0] volt;
        logic [SAMPLE_W-1:0] curr;
        roll = $urandom_range(99);
        if (roll < connect_pct) begin
            send_item(REQ_CONNECT, $urandom, $urandom, $urandom, $urandom);
        end else if (roll < connect_pct + tick_pct) begin
            send_item(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
        end else if (roll < connect_pct + tick_pct + temp_pct) begin
            send_item(REQ_TEMP, $urandom, $urandom, temp_near_limit(),
                      $urandom_range(99) < 85);
        end else begin
            // new operating point for each averaging block
            if (adc_in_block == 0) begin
                volt_center = pick_center(limits.overvolt_limit, limits.full_voltage_limit);
                curr_center = pick_center(limits.overcurrent_limit, limits.low_current_limit);
            end
            adc_in_block = (adc_in_block + 1) % SAMPLES_PER_AVERAGE;
            volt = sample_near(volt_center);
            curr = sample_near(curr_center);
            send_item(REQ_ADC, volt, curr, $urandom, $urandom);
        end
    endtask

    initial begin
        cfg_t lim;
        limits = '{RST_OVERTEMP, RST_OVERVOLT, RST_OVERCURRENT, RST_FULL_VOLT,
                   RST_LOW_CURRENT};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, slot rotation, failed read, all request kinds
        send_item(REQ_TICK, '0, '0, '0, 1'b0);
        send_item(REQ_TEMP, '1, '1, 13'h0FFF, 1'b1);
        send_item(REQ_TEMP, '0, '0, 13'h1000, 1'b1);
        send_item(REQ_TEMP, '0, '0, 13'h0555, 1'b0);
        send_item(REQ_TEMP, '0, '0, 13'h1FFF, 1'b1);
        send_item(REQ_TICK, '1, '1, '1, 1'b1);
        for (int i = 0; i < SAMPLES_PER_AVERAGE; i++) begin
            send_item(REQ_ADC, (i < 8) ? 16'hFFFF : 16'h0000,
                      (i < 8) ? 16'h0000 : 16'hFFFF, '1, 1'b1);
        end
        send_item(REQ_TICK, '0, '0, '0, 1'b0);
        send_item(REQ_CONNECT, '1, '1, '1, 1'b1);
        send_item(REQ_TICK, '0, '0, '0, 1'b0);
        adc_in_block = 0;

        // upper extremes: no test can pass
        set_limits('{13'h0FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
        tick_pct = 35; connect_pct = 3; temp_pct = 15;
        repeat (120) random_item();

        lim.overtemp_limit     = TEMP_W'($urandom);
        lim.overvolt_limit     = SAMPLE_W'($urandom_range(30000, 1000));
        lim.overcurrent_limit  = SAMPLE_W'($urandom_range(5000, 100));
        lim.full_voltage_limit = SAMPLE_W'($urandom_range(10000, 1000));
        lim.low_current_limit  = SAMPLE_W'($urandom_range(500, 20));
        set_limits(lim);
        tick_pct = 40; connect_pct = 2; temp_pct = 15;
        calm = 1'b1;
        repeat (80) random_item();
        calm = 1'b0;
        repeat (80) random_item();

        set_limits('{RST_OVERTEMP, RST_OVERVOLT, RST_OVERCURRENT, RST_FULL_VOLT,
                     RST_LOW_CURRENT});
        tick_pct = 40; connect_pct = 1; temp_pct = 15;
        rx_hold = 1'b1;
        repeat (75) random_item();
        drain();
        repeat (75) random_item();

        // lower extremes: long tick runs so every lane can latch
        set_limits('{13'h1000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
        tick_pct = 72; connect_pct = 0; temp_pct = 6;
        repeat (300) random_item();

        drain();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
